// File: hdl/pcam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcam_pkg
// Shared types and codes of the poll/command ARQ master: item and result
// layouts, event and command codes, link modes and configuration indexes.
// ----------------------------------------------------------------------------
package pcam_pkg;

  localparam int CNT_W = 20;
  localparam int SEQ_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Input command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_DATA = 2'd1;
  localparam logic [1:0] CMD_ACK  = 2'd2;
  localparam logic [1:0] CMD_NEW  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_POLL_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_DATA_WAIT     = 2'd1;
  localparam logic [1:0] CFG_ACK_WAIT      = 2'd2;
  localparam logic [1:0] CFG_ATTEMPTS      = 2'd3;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] RST_POLL_INTERVAL = 20'd30000;
  localparam logic [CNT_W-1:0] RST_DATA_WAIT     = 20'd3000;
  localparam logic [CNT_W-1:0] RST_ACK_WAIT      = 20'd3000;
  localparam logic [3:0]       RST_ATTEMPTS      = 4'd3;

  // Result event codes
  typedef enum logic [3:0] {
    EV_SEND_REQ    = 4'd0,
    EV_SEND_CMD    = 4'd1,
    EV_DATA_ACC    = 4'd2,
    EV_DATA_IGN    = 4'd3,
    EV_PAYLOAD_BAD = 4'd4,
    EV_ACK_MATCH   = 4'd5,
    EV_ACK_IGN     = 4'd6,
    EV_DATA_TMO    = 4'd7,
    EV_CMD_FAIL    = 4'd8,
    EV_CMD_REFUSED = 4'd9
  } event_t;

  // Link state, one-hot
  typedef enum logic [2:0] {
    M_IDLE      = 3'b001,
    M_WAIT_DATA = 3'b010,
    M_WAIT_ACK  = 3'b100
  } mode_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [SEQ_W-1:0] seq_in;
    logic             payload_ok;
    logic [7:0]       zone_in;
    logic             irrigate_in;
  } item_t;

  typedef struct packed {
    logic [3:0]       event_res;
    logic [SEQ_W-1:0] seq_out;
    logic [7:0]       zone_out;
    logic             irrigate_out;
    logic [3:0]       attempt;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] poll_interval;
    logic [CNT_W-1:0] data_wait_limit;
    logic [CNT_W-1:0] ack_wait_limit;
    logic [3:0]       attempt_limit;
  } cfg_t;

  // Results produced by one processed item
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic hold_valid;
    logic go;
  } core_stat_t;

  typedef struct packed {
    logic space_ok;
    logic empty;
  } fifo_stat_t;

endpackage

// File: hdl/pcam_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcam channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface pcam_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] seq_in;
  logic        payload_ok;
  logic [7:0]  zone_in;
  logic        irrigate_in;

  modport source (output valid, cmd, seq_in, payload_ok, zone_in, irrigate_in,
                  input ready);
  modport sink   (input valid, cmd, seq_in, payload_ok, zone_in, irrigate_in,
                  output ready);
endinterface

interface pcam_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [31:0] seq_out;
  logic [7:0]  zone_out;
  logic        irrigate_out;
  logic [3:0]  attempt;
  logic        last;

  modport source (output valid, event_res, seq_out, zone_out, irrigate_out, attempt,
                  last, input ready);
  modport sink   (input valid, event_res, seq_out, zone_out, irrigate_out, attempt,
                  last, output ready);
endinterface

// File: hdl/pcam_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcam_core
// Input register plus the link state machine: one held item is processed
// per cycle while the result queue has room, into zero, one or two results.
// ----------------------------------------------------------------------------
module pcam_core (
  input  logic                clk,
  input  logic                rst,
  pcam_in_if.sink             in_ch,
  input  pcam_pkg::cfg_t      cfg,
  input  pcam_pkg::fifo_stat_t fstat,
  output pcam_pkg::push_t     push,
  output pcam_pkg::core_stat_t stat
);
  import pcam_pkg::*;

  // Input register
  logic  hold_valid;
  item_t hold_item;
  logic  go;

  // Link state
  mode_t            mode, mode_next;
  logic [SEQ_W-1:0] seq_counter, seq_counter_next;
  logic [3:0]       retry_count, retry_count_next;
  logic [CNT_W-1:0] wait_elapsed, wait_elapsed_next;
  logic [CNT_W-1:0] poll_elapsed, poll_elapsed_next;
  logic [7:0]       pending_zone, pending_zone_next;
  logic             pending_irrigate, pending_irrigate_next;

  res_t       res_a [2];
  logic [1:0] n;

  function automatic res_t mk_res(event_t ev, logic [SEQ_W-1:0] sq, logic [7:0] zn,
                                  logic irr, logic [3:0] att);
    res_t r;
    r.event_res    = ev;
    r.seq_out      = sq;
    r.zone_out     = zn;
    r.irrigate_out = irr;
    r.attempt      = att;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic logic [SEQ_W-1:0] seq_inc(logic [SEQ_W-1:0] s);
    logic [SEQ_W-1:0] t;
    t = s + {{(SEQ_W-1){1'b0}}, 1'b1};
    if (t == '0) t = {{(SEQ_W-1){1'b0}}, 1'b1};
    return t;
  endfunction

  assign go           = hold_valid && fstat.space_ok;
  assign in_ch.ready  = !hold_valid || go;
  assign stat.hold_valid = hold_valid;
  assign stat.go         = go;

  // Hold register for the accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      hold_valid <= 1'b1;
    end else if (go) begin
      hold_valid <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      hold_item.cmd         <= in_ch.cmd;
      hold_item.seq_in      <= in_ch.seq_in;
      hold_item.payload_ok  <= in_ch.payload_ok;
      hold_item.zone_in     <= in_ch.zone_in;
      hold_item.irrigate_in <= in_ch.irrigate_in;
    end
  end

  // Step logic
  always_comb begin
    logic       is_wd;
    logic       is_wa;
    logic [3:0] rc_inc;
    is_wd = (mode == M_WAIT_DATA);
    is_wa = (mode == M_WAIT_ACK);
    rc_inc = retry_count + 4'd1;

    mode_next             = mode;
    seq_counter_next      = seq_counter;
    retry_count_next      = retry_count;
    wait_elapsed_next     = wait_elapsed;
    poll_elapsed_next     = poll_elapsed;
    pending_zone_next     = pending_zone;
    pending_irrigate_next = pending_irrigate;
    res_a[0] = '0;
    res_a[1] = '0;
    n = 2'd0;

    case (hold_item.cmd)
      CMD_TICK: begin
        if ((is_wd || is_wa) && wait_elapsed != CNT_MAX)
          wait_elapsed_next = wait_elapsed + 1'b1;
        if (poll_elapsed != CNT_MAX)
          poll_elapsed_next = poll_elapsed + 1'b1;
        // Wait timeouts
        if (is_wd && wait_elapsed_next >= cfg.data_wait_limit) begin
          mode_next = M_IDLE;
          res_a[0] = mk_res(EV_DATA_TMO, seq_counter, 8'd0, 1'b0, 4'd0);
          n = 2'd1;
        end else if (is_wa && wait_elapsed_next >= cfg.ack_wait_limit) begin
          if (rc_inc < cfg.attempt_limit) begin
            retry_count_next  = rc_inc;
            wait_elapsed_next = '0;
            res_a[0] = mk_res(EV_SEND_CMD, seq_counter, pending_zone, pending_irrigate,
                              rc_inc + 4'd1);
          end else begin
            retry_count_next = 4'd0;
            mode_next        = M_IDLE;
            res_a[0] = mk_res(EV_CMD_FAIL, seq_counter, pending_zone, pending_irrigate,
                              rc_inc);
          end
          n = 2'd1;
        end
        // Poll request once idle
        if (mode_next != M_WAIT_DATA && mode_next != M_WAIT_ACK &&
            poll_elapsed_next >= cfg.poll_interval) begin
          poll_elapsed_next = '0;
          seq_counter_next  = seq_inc(seq_counter);
          mode_next         = M_WAIT_DATA;
          wait_elapsed_next = '0;
          res_a[n[0]] = mk_res(EV_SEND_REQ, seq_inc(seq_counter), 8'd0, 1'b0, 4'd0);
          n = n + 2'd1;
        end
      end
      CMD_DATA: begin
        if (is_wd && hold_item.seq_in == seq_counter) begin
          if (hold_item.payload_ok) begin
            mode_next = M_IDLE;
            res_a[0] = mk_res(EV_DATA_ACC, seq_counter, 8'd0, 1'b0, 4'd0);
          end else begin
            res_a[0] = mk_res(EV_PAYLOAD_BAD, seq_counter, 8'd0, 1'b0, 4'd0);
          end
        end else begin
          res_a[0] = mk_res(EV_DATA_IGN, hold_item.seq_in, 8'd0, 1'b0, 4'd0);
        end
        n = 2'd1;
      end
      CMD_ACK: begin
        if (is_wa && hold_item.seq_in == seq_counter) begin
          res_a[0] = mk_res(EV_ACK_MATCH, seq_counter, pending_zone, pending_irrigate,
                            rc_inc);
          retry_count_next  = 4'd0;
          mode_next         = M_IDLE;
          poll_elapsed_next = '0;
        end else begin
          res_a[0] = mk_res(EV_ACK_IGN, hold_item.seq_in, 8'd0, 1'b0, 4'd0);
        end
        n = 2'd1;
      end
      default: begin
        // New command: refused while a wait is open
        if (is_wd || is_wa) begin
          res_a[0] = mk_res(EV_CMD_REFUSED, '0, hold_item.zone_in,
                            hold_item.irrigate_in, 4'd0);
        end else begin
          seq_counter_next      = seq_inc(seq_counter);
          pending_zone_next     = hold_item.zone_in;
          pending_irrigate_next = hold_item.irrigate_in;
          retry_count_next      = 4'd0;
          mode_next             = M_WAIT_ACK;
          wait_elapsed_next     = '0;
          res_a[0] = mk_res(EV_SEND_CMD, seq_inc(seq_counter), hold_item.zone_in,
                            hold_item.irrigate_in, 4'd1);
        end
        n = 2'd1;
      end
    endcase

    // Mark the final result of the transaction
    if (n == 2'd2) res_a[1].last = 1'b1;
    else if (n == 2'd1) res_a[0].last = 1'b1;
  end

  assign push.n  = go ? n : 2'd0;
  assign push.r0 = res_a[0];
  assign push.r1 = res_a[1];

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= M_IDLE;
      seq_counter      <= '0;
      retry_count      <= 4'd0;
      wait_elapsed     <= '0;
      poll_elapsed     <= RST_POLL_INTERVAL;
      pending_zone     <= 8'd0;
      pending_irrigate <= 1'b0;
    end else if (go) begin
      mode             <= mode_next;
      seq_counter      <= seq_counter_next;
      retry_count      <= retry_count_next;
      wait_elapsed     <= wait_elapsed_next;
      poll_elapsed     <= poll_elapsed_next;
      pending_zone     <= pending_zone_next;
      pending_irrigate <= pending_irrigate_next;
    end
  end

endmodule

// File: hdl/pcam_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcam_res_fifo
// Result queue: takes up to two results a cycle, pops one when out_ch.ready.
// ----------------------------------------------------------------------------
module pcam_res_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pcam_pkg::push_t              push,
  pcam_out_if.source                   out_ch,
  output pcam_pkg::fifo_stat_t         fstat,
  output logic [$clog2(DEPTH+1)-1:0]   level
);
  import pcam_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH-1);

  res_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr, wr_p1;
  logic [CW-1:0] cnt;
  logic          pop;
  res_t          head;

  assign wr_p1 = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
  assign head  = entries[rd_ptr];
  assign pop   = out_ch.valid && out_ch.ready;

  assign out_ch.valid        = (cnt != '0);
  assign out_ch.event_res    = head.event_res;
  assign out_ch.seq_out      = head.seq_out;
  assign out_ch.zone_out     = head.zone_out;
  assign out_ch.irrigate_out = head.irrigate_out;
  assign out_ch.attempt      = head.attempt;
  assign out_ch.last         = head.last;

  assign fstat.space_ok = (cnt <= CW'(DEPTH-2));
  assign fstat.empty    = (cnt == '0);
  assign level          = cnt;

  // Storage writes
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) entries[wr_ptr] <= push.r0;
    if (push.n == 2'd2) entries[wr_p1]  <= push.r1;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      case (push.n)
        2'd1:    wr_ptr <= wr_p1;
        2'd2:    wr_ptr <= (wr_p1 == LAST_PTR) ? '0 : wr_p1 + 1'b1;
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      cnt <= cnt + CW'(push.n) - CW'(pop);
    end
  end

endmodule

// File: hdl/poll_command_arq_master_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poll_command_arq_master_unit
// Stop-and-wait master of a radio link: polls for sensor data, sends
// irrigation commands with retries, matches sequence numbers of replies.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    cmd, seq_in, payload_ok, zone_in, irrigate_in
//   out_ch   out  valid/ready    event_res, seq_out, zone_out, irrigate_out,
//                                attempt, last
//   cfg      in   cfg_we only    cfg_index, cfg_data
//
// One item is taken per cycle while in_ch.ready; it queues its results (a tick
// can give two) on leaving the input register; out_ch.ready pops one a cycle.
// The input register is processed only while the result queue has room for
// two entries, so a stalled out_ch fills the queue and then drops in_ch.ready.
// Synchronous active-high reset; no clearing pass, ready from the first cycle.
// ----------------------------------------------------------------------------
module poll_command_arq_master_unit #(
  parameter int RES_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  pcam_in_if.sink     in_ch,
  pcam_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import pcam_pkg::*;

  localparam int LVL_W = $clog2(RES_DEPTH+1);

  cfg_t             cfg;
  push_t            push;
  core_stat_t       core_stat;
  fifo_stat_t       fstat;
  logic [LVL_W-1:0] level;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_interval   <= RST_POLL_INTERVAL;
      cfg.data_wait_limit <= RST_DATA_WAIT;
      cfg.ack_wait_limit  <= RST_ACK_WAIT;
      cfg.attempt_limit   <= RST_ATTEMPTS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLL_INTERVAL: cfg.poll_interval   <= cfg_data;
        CFG_DATA_WAIT:     cfg.data_wait_limit <= cfg_data;
        CFG_ACK_WAIT:      cfg.ack_wait_limit  <= cfg_data;
        CFG_ATTEMPTS:      cfg.attempt_limit   <= cfg_data[3:0];
        default:           cfg.attempt_limit   <= cfg.attempt_limit;
      endcase
    end
  end

  pcam_core u_core (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .cfg   (cfg),
    .fstat (fstat),
    .push  (push),
    .stat  (core_stat)
  );

  pcam_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .out_ch (out_ch),
    .fstat  (fstat),
    .level  (level)
  );

`ifndef ASSERT_OFF
  // Queue never overfills
  a_level: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(RES_DEPTH))
    else $error("result queue overfilled");

  // A held transaction that is not processed stays held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    core_stat.hold_valid && !core_stat.go |=> core_stat.hold_valid)
    else $error("held transaction lost");

  // Two results: only the second carries last
  a_last: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> !push.r0.last && push.r1.last)
    else $error("last flag misplaced");

  // Processing only with room in the queue
  a_room: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> core_stat.go && !(level > LVL_W'(RES_DEPTH-2)))
    else $error("push without room");
`endif

endmodule
